// File: rtl/etm_pkg.sv
`timescale 1ns / 1ps

package etm_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 27;
    localparam int ITER_W    = 16;
    localparam int CFG_W     = 16;

    typedef struct packed {
        logic signed [VALUE_W-1:0] c_re;
        logic signed [VALUE_W-1:0] c_im;
    } t_point;

    typedef struct packed {
        logic                      escaped;
        logic        [ITER_W-1:0]  iterations;
        logic signed [VALUE_W-1:0] z_re;
        logic signed [VALUE_W-1:0] z_im;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_RR,
        S_MUL_II,
        S_MUL_RI,
        S_TEST,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_RR,
        SEL_II,
        SEL_RI
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     cap_sr;
        logic     cap_si;
        logic     cap_diff;
        logic     update;
    } t_dp_ctrl;

endpackage

// File: rtl/etm_datapath.sv
`timescale 1ns / 1ps

module etm_datapath
    import etm_pkg::*;
(
    input  logic                      i_clk,
    input  t_dp_ctrl                  i_ctrl,
    input  t_point                    i_point,
    output logic                      o_escape,
    output logic signed [VALUE_W-1:0] o_z_re,
    output logic signed [VALUE_W-1:0] o_z_im
);

    localparam int PW    = 2 * VALUE_W;
    localparam int CMP_W = (2 * FRAC_BITS + 3 > PW + 1) ? 2 * FRAC_BITS + 3 : PW + 1;
    localparam logic [CMP_W-1:0] THRESH = CMP_W'(1) << (2 * FRAC_BITS + 2);

    logic signed [VALUE_W-1:0] r_z_re;
    logic signed [VALUE_W-1:0] r_z_im;
    logic signed [VALUE_W-1:0] r_c_re;
    logic signed [VALUE_W-1:0] r_c_im;
    logic signed [PW-1:0]      r_prod;
    logic signed [PW-1:0]      r_sr;
    logic signed [PW-1:0]      r_si;
    logic signed [PW:0]        r_diff;

    logic signed [VALUE_W-1:0] op_a;
    logic signed [VALUE_W-1:0] op_b;
    logic signed [PW-1:0]      prod_full;
    logic        [CMP_W-1:0]   mag_sq;
    logic signed [PW:0]        diff;
    logic signed [PW:0]        re_sh;
    logic signed [PW+1:0]      re_sum;
    logic signed [PW-1:0]      im_sh;
    logic signed [PW:0]        im_sum;
    logic signed [VALUE_W-1:0] n_z_re;
    logic signed [VALUE_W-1:0] n_z_im;
    logic                      re_fits;
    logic                      im_fits;

    always_comb begin
        unique case (i_ctrl.mul_sel)
            SEL_RR: begin
                op_a = r_z_re;
                op_b = r_z_re;
            end
            SEL_II: begin
                op_a = r_z_im;
                op_b = r_z_im;
            end
            SEL_RI: begin
                op_a = r_z_re;
                op_b = r_z_im;
            end
            default: begin
                op_a = r_z_re;
                op_b = r_z_im;
            end
        endcase
    end

    assign prod_full = op_a * op_b;

    // squares are never negative, so zero-extend them for the magnitude
    assign mag_sq   = CMP_W'($unsigned(r_sr)) + CMP_W'($unsigned(r_si));
    assign o_escape = mag_sq > THRESH;
    assign diff     = {r_sr[PW-1], r_sr} - {r_si[PW-1], r_si};

    // floor shift, add c, then saturate to the value range
    assign re_sh  = r_diff >>> FRAC_BITS;
    assign re_sum = {re_sh[PW], re_sh} + {{(PW + 2 - VALUE_W){r_c_re[VALUE_W-1]}}, r_c_re};
    assign im_sh  = r_prod >>> (FRAC_BITS - 1);
    assign im_sum = {im_sh[PW-1], im_sh} + {{(PW + 1 - VALUE_W){r_c_im[VALUE_W-1]}}, r_c_im};

    assign re_fits = (&re_sum[PW+1:VALUE_W-1]) || !(|re_sum[PW+1:VALUE_W-1]);
    assign im_fits = (&im_sum[PW:VALUE_W-1]) || !(|im_sum[PW:VALUE_W-1]);

    always_comb begin
        if (re_fits) begin
            n_z_re = re_sum[VALUE_W-1:0];
        end else begin
            n_z_re = {re_sum[PW+1], {(VALUE_W - 1){!re_sum[PW+1]}}};
        end
        if (im_fits) begin
            n_z_im = im_sum[VALUE_W-1:0];
        end else begin
            n_z_im = {im_sum[PW], {(VALUE_W - 1){!im_sum[PW]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_z_re <= '0;
            r_z_im <= '0;
            r_c_re <= i_point.c_re;
            r_c_im <= i_point.c_im;
        end else if (i_ctrl.update) begin
            r_z_re <= n_z_re;
            r_z_im <= n_z_im;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= prod_full;
        end
        if (i_ctrl.cap_sr) begin
            r_sr <= r_prod;
        end
        if (i_ctrl.cap_si) begin
            r_si <= r_prod;
        end
        if (i_ctrl.cap_diff) begin
            r_diff <= diff;
        end
    end

    assign o_z_re = r_z_re;
    assign o_z_im = r_z_im;

endmodule

// File: rtl/escape_time_iteration_top.sv
`timescale 1ns / 1ps
// Each iteration steps through MUL_RR, MUL_II, MUL_RI, TEST and UPDATE around
// one shared 32x32 multiplier (three products, an escape test and a z update);
// the strobe comes once the point escapes or reaches the iteration limit.
// A new point is taken the cycle after the strobe; the receiver cannot stall.
// Synchronous active-low reset returns to idle with max_iter = 1.
module escape_time_iteration_top
    import etm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_point           i_point,
    output logic             o_result_valid,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_state           r_state;
    t_state           n_state;
    logic [CFG_W-1:0] r_max_iter;
    logic [CFG_W-1:0] r_limit;
    logic [CFG_W-1:0] r_iter;
    logic [CFG_W-1:0] n_iter;
    logic             r_escaped;
    logic             n_escaped;
    logic [CFG_W-1:0] iter_inc;
    logic             escape;
    t_dp_ctrl         ctrl;
    logic signed [VALUE_W-1:0] z_re;
    logic signed [VALUE_W-1:0] z_im;

    assign o_cfg_ready = 1'b1;
    assign iter_inc    = r_iter + CFG_W'(1);

    always_comb begin
        n_state   = r_state;
        n_iter    = r_iter;
        n_escaped = r_escaped;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_iter    = '0;
                    n_escaped = 1'b0;
                    n_state   = (r_max_iter == '0) ? S_DONE : S_MUL_RR;
                end
            end
            S_MUL_RR: n_state = S_MUL_II;
            S_MUL_II: n_state = S_MUL_RI;
            S_MUL_RI: n_state = S_TEST;
            S_TEST: begin
                if (escape) begin
                    n_escaped = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_iter  = iter_inc;
                n_state = (iter_inc == r_limit) ? S_DONE : S_MUL_RR;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl           = '0;
        ctrl.mul_sel   = SEL_RR;
        busy           = 1'b1;
        o_result_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            S_MUL_RR: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = SEL_RR;
            end
            S_MUL_II: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = SEL_II;
                ctrl.cap_sr  = 1'b1;
            end
            S_MUL_RI: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = SEL_RI;
                ctrl.cap_si  = 1'b1;
            end
            S_TEST:   ctrl.cap_diff = 1'b1;
            S_UPDATE: ctrl.update   = 1'b1;
            S_DONE:   o_result_valid = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_max_iter <= CFG_W'(1);
            r_limit    <= '0;
            r_iter     <= '0;
            r_escaped  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_iter    <= n_iter;
            r_escaped <= n_escaped;
            if (r_state == S_IDLE && start) begin
                r_limit <= r_max_iter;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_iter <= i_cfg_data;
            end
        end
    end

    etm_datapath u_datapath (
        .i_clk    (i_clk),
        .i_ctrl   (ctrl),
        .i_point  (i_point),
        .o_escape (escape),
        .o_z_re   (z_re),
        .o_z_im   (z_im)
    );

    assign o_result.escaped    = r_escaped;
    assign o_result.iterations = ITER_W'(r_iter);
    assign o_result.z_re       = z_re;
    assign o_result.z_im       = z_im;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && r_escaped |-> r_iter < r_limit)
        else $error("escape index not below iteration limit");

    a_inside_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !r_escaped |-> r_iter == r_limit)
        else $error("non-escaped point did not run to the limit");

endmodule

// File: tb/escape_time_iteration_top_tb.sv
`timescale 1ns / 1ps

module escape_time_iteration_top_tb;
    import etm_pkg::*;

    localparam logic signed [VALUE_W-1:0] ONE  = 32'sh0800_0000;
    localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;

    localparam logic signed [67:0] ESC_LIMIT = 68'sd1 <<< (2 * FRAC_BITS + 2);
    localparam logic signed [67:0] Z_MAX     = 68'sh7FFF_FFFF;
    localparam logic signed [67:0] Z_MIN     = -68'sh8000_0000;

    typedef struct packed {
        logic [CFG_W-1:0] limit;
        t_point           point;
        logic             typed;
        t_result          want;
    } t_probe;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_point           i_point;
    logic             o_result_valid;
    t_result          o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    t_result          pending_results[$];
    t_probe           probes[$];
    logic [CFG_W-1:0] iter_cap;
    logic             mismatch_seen;
    t_result          got_want;

    escape_time_iteration_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_point        (i_point),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [67:0] clamp_value(input logic signed [67:0] v);
        if (v > Z_MAX) return Z_MAX;
        if (v < Z_MIN) return Z_MIN;
        return v;
    endfunction

    // Iterate z = z^2 + c from zero; squares stay exact at 68 bits.
    function automatic t_result escape_time_predict(input t_point p,
                                                    input logic [CFG_W-1:0] limit);
        logic signed [67:0] zr, zi, sq_re, sq_im, nxt_re, nxt_im;
        t_result            r;
        int unsigned        n;
        r = '0;
        r.iterations = limit;
        zr = '0;
        zi = '0;
        n = 0;
        while (!r.escaped && n < limit) begin
            sq_re = zr * zr;
            sq_im = zi * zi;
            if (sq_re + sq_im > ESC_LIMIT) begin
                r.escaped = 1'b1;
                r.iterations = n[ITER_W-1:0];
            end else begin
                nxt_re = ((sq_re - sq_im) >>> FRAC_BITS) + $signed(p.c_re);
                nxt_im = ((zr * zi) >>> (FRAC_BITS - 1)) + $signed(p.c_im);
                zr = clamp_value(nxt_re);
                zi = clamp_value(nxt_im);
            end
            n++;
        end
        r.z_re = zr[VALUE_W-1:0];
        r.z_im = zi[VALUE_W-1:0];
        return r;
    endfunction

    function automatic void add_probe(input logic [CFG_W-1:0] limit,
                                      input logic [VALUE_W-1:0] c_re,
                                      input logic [VALUE_W-1:0] c_im,
                                      input logic typed, input t_result want);
        t_probe row;
        row.limit = limit;
        row.point.c_re = c_re;
        row.point.c_im = c_im;
        row.typed = typed;
        row.want = want;
        probes.push_back(row);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    // Write max_iter once every pending point has come back.
    task automatic write_max_iter(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        iter_cap = value;
    endtask

    // Hold start until the request is taken; leave it high for back-to-back use.
    task automatic issue_point(input t_point p, input logic typed, input t_result want);
        start <= 1'b1;
        i_point <= p;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(typed ? want : escape_time_predict(p, iter_cap));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, o_result);
                mismatch_seen = 1'b1;
            end else begin
                got_want = pending_results.pop_front();
                check_field("escaped", got_want.escaped, o_result.escaped);
                check_field("iterations", got_want.iterations, o_result.iterations);
                check_field("z_re", got_want.z_re, o_result.z_re);
                check_field("z_im", got_want.z_im, o_result.z_im);
            end
        end
    end

    initial begin
        int     idle_pct [4] = '{0, 63, 0, 19};
        t_point pt;
        mismatch_seen = 1'b0;
        iter_cap = 16'd1;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_point <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;

        // limit 1 just copies c into z; limit 0 runs nothing
        add_probe(1, 0, 0, 1, '{1'b0, 16'd1, 32'd0, 32'd0});
        add_probe(1, VMAX, VMAX, 1, '{1'b0, 16'd1, VMAX, VMAX});
        add_probe(1, VMIN, VMIN, 1, '{1'b0, 16'd1, VMIN, VMIN});
        add_probe(1, VMAX, VMIN, 1, '{1'b0, 16'd1, VMAX, VMIN});
        add_probe(0, VMAX, VMIN, 1, '{1'b0, 16'd0, 32'd0, 32'd0});
        add_probe(0, ONE, -ONE, 1, '{1'b0, 16'd0, 32'd0, 32'd0});
        add_probe(2, 3 * ONE, 0, 1, '{1'b1, 16'd1, 3 * ONE, 32'd0});
        add_probe(2, VMIN, 0, 1, '{1'b1, 16'd1, VMIN, 32'd0});
        add_probe(2, 0, VMAX, 1, '{1'b1, 16'd1, 32'd0, VMAX});
        // |z|^2 exactly four must not count as escaped
        add_probe(2, 2 * ONE, 0, 0, '0);
        add_probe(2, 0, -2 * ONE, 0, '0);
        add_probe(16, -2 * ONE, 0, 0, '0);
        add_probe(16, ONE / 4, 0, 0, '0);
        add_probe(16, -(3 * ONE) / 4, 32'sh00CC_CCCD, 0, '0);
        add_probe(16, -ONE, 0, 0, '0);
        add_probe(16, 0, ONE, 0, '0);
        add_probe(16, -ONE / 8, -ONE / 3, 0, '0);
        add_probe(65535, ONE, ONE, 0, '0);
        add_probe(65535, -ONE, 0, 0, '0);
        add_probe(1, ONE, -ONE, 1, '{1'b0, 16'd1, ONE, -ONE});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probes[r]) begin
            if (probes[r].limit != iter_cap) write_max_iter(probes[r].limit);
            issue_point(probes[r].point, probes[r].typed, probes[r].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 320; k++) begin
                if (k % 40 == 0) begin
                    case ($urandom_range(0, 3))
                        0: write_max_iter(16'd1);
                        1: write_max_iter(16'($urandom_range(2, 16)));
                        2: write_max_iter(16'($urandom_range(17, 64)));
                        default: write_max_iter(16'd255);
                    endcase
                end
                while ($urandom_range(0, 99) < idle_pct[ph]) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                end
                // mostly points near the set, where the loop runs long
                if ($urandom_range(0, 3) == 0) begin
                    pt.c_re = $urandom;
                    pt.c_im = $urandom;
                end else begin
                    pt.c_re = $urandom_range(0, 32'h1400_0000) - 32'h1000_0000;
                    pt.c_im = $urandom_range(0, 32'h1400_0000) - 32'h0A00_0000;
                end
                issue_point(pt, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!mismatch_seen) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: escape_time_iteration_top.f
rtl/etm_pkg.sv
rtl/etm_datapath.sv
rtl/escape_time_iteration_top.sv
tb/escape_time_iteration_top_tb.sv
